// ----- sv/mrtu_pkg.sv -----
package mrtu_pkg;

    localparam int REG_DEPTH_DEF = 16;
    localparam int MAX_REPLY     = 37;
    localparam int MAX_READ_REGS = (MAX_REPLY - 5) / 2;
    localparam int FRAME_LEN     = 8;
    localparam int KW            = $clog2(MAX_READ_REGS + 1);

    localparam logic [7:0]  FN_READ        = 8'h03;
    localparam logic [7:0]  FN_WRITE       = 8'h06;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
    localparam logic [15:0] REG1_RST       = 16'd5678;
    localparam logic [15:0] REG2_RST       = 16'd90;

    // Register select bit of the configuration address (byte address 4*i).
    localparam logic CFG_SLAVE_ADDR = 1'b0;

    // Byte positions inside a request frame.
    localparam logic [2:0] FB_ADDR   = 3'd0;
    localparam logic [2:0] FB_FN     = 3'd1;
    localparam logic [2:0] FB_REG_HI = 3'd2;
    localparam logic [2:0] FB_REG_LO = 3'd3;
    localparam logic [2:0] FB_VAL_HI = 3'd4;
    localparam logic [2:0] FB_VAL_LO = 3'd5;
    localparam logic [2:0] FB_CRC_LO = 3'd6;
    localparam logic [2:0] FB_CRC_HI = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_DAT,
        ST_CHECK,
        ST_RD_HDR,
        ST_RD_REQ,
        ST_RD_HI,
        ST_RD_LO,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_ECHO_RD,
        ST_ECHO_PUSH
    } t_state;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] reg_rst_val(input int unsigned idx);
        logic [15:0] v;
        case (idx)
            1: v = REG1_RST;
            2: v = REG2_RST;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/mrtu_rx_if.sv -----
interface mrtu_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- sv/mrtu_tx_if.sv -----
interface mrtu_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ----- sv/mrtu_crc.sv -----
module mrtu_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clr,
    input  logic        i_upd,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mrtu_pkg::*;

    logic [15:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_clr) begin
            r_crc <= CRC_INIT;
        end else if (i_upd) begin
            r_crc <= crc16_byte(r_crc, i_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

// ----- sv/mrtu_fbuf.sv -----
module mrtu_fbuf (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [2:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic       i_re,
    input  logic [2:0] i_raddr,
    output logic [7:0] o_rdata
);
    import mrtu_pkg::*;

    logic [7:0] r_mem [FRAME_LEN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mrtu_regs.sv -----
module mrtu_regs #(
    parameter int REG_DEPTH = mrtu_pkg::REG_DEPTH_DEF,
    parameter int AW        = $clog2(REG_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    import mrtu_pkg::*;

    logic [15:0]          r_mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] r_valid;
    logic [15:0]          r_rdata;

    // An entry that was never written reads as its power-on value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : reg_rst_val(int'(i_raddr));
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/modbus_rtu_slave_frame_handler_core.sv -----
// Modbus RTU slave request handler for function codes 3 (read holding
// registers) and 6 (write single register).
// Received bytes enter on the i_rx channel, one byte per transaction, with
// frame_end set on the last byte of a frame by an external idle detector.
// Reply bytes leave on the o_tx channel, one byte per transaction, with
// last_byte set on the final byte of a reply. Frames that are short, carry
// another station address, fail the CRC, use another function code or ask
// for an impossible read produce no transaction on o_tx.
// While a frame is being received, a byte is taken every cycle. After the
// byte that ends a full frame, i_rx stays not ready until the 8 buffered
// bytes are scanned (one frame buffer read and one CRC step per byte) and
// checked and any reply is handed to the output register: the header bytes,
// each register read from the register store (one port, registered read),
// the CRC bytes, or the write echo with each byte read back from the buffer.
// A stalled receiver holds the output register and the sequencer waits for
// it; after the last reply byte is loaded, the next frame is accepted even
// while that byte is still pending.
// Reset (synchronous, active low) sets the station address to 1, the
// register store to its power-on values and clears the frame byte count.
// The station address is written through the APB port at byte address 0.
module modbus_rtu_slave_frame_handler_core #(
    parameter int REG_DEPTH = mrtu_pkg::REG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrtu_rx_if.sink     i_rx,
    mrtu_tx_if.source   o_tx,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrtu_pkg::*;

    localparam int AW = $clog2(REG_DEPTH);

    t_state r_state, n_state;

    logic [7:0]    r_slave_addr;
    logic [3:0]    r_count, n_count;
    logic [2:0]    r_idx, n_idx;
    logic [KW-1:0] r_k, n_k;

    // Fields of the request, collected while the buffer is scanned.
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_fn, n_fn;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_crc_rx, n_crc_rx;

    // Output register toward the transmitter.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       slot_free;
    logic       push;
    logic [7:0] push_byte;
    logic       push_last;

    logic       fb_we, fb_re;
    logic [2:0] fb_raddr;
    logic [7:0] fb_rdata;

    logic          rs_we, rs_re;
    logic [15:0]   rd_sum;
    logic [15:0]   rs_rdata;

    logic        crc_clr, crc_upd;
    logic [7:0]  crc_byte;
    logic [15:0] crc_val;

    logic        rd_ok;
    logic [16:0] rd_end;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_SLAVE_ADDR) ? {24'd0, r_slave_addr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_SLAVE_ADDR)) begin
            r_slave_addr <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------------
    // Storage and CRC unit
    // ---------------------------------------------------------------------
    mrtu_fbuf u_fbuf (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (r_count[2:0]),
        .i_wdata (i_rx.rx_byte),
        .i_re    (fb_re),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    // The read address is start plus offset; the range check guarantees it
    // stays inside the store, so the low bits are the whole address.
    assign rd_sum = r_addr + 16'(r_k);

    mrtu_regs #(
        .REG_DEPTH (REG_DEPTH),
        .AW        (AW)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rs_we),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (r_cnt),
        .i_re    (rs_re),
        .i_raddr (rd_sum[AW-1:0]),
        .o_rdata (rs_rdata)
    );

    mrtu_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (crc_clr),
        .i_upd   (crc_upd),
        .i_byte  (crc_byte),
        .o_crc   (crc_val)
    );

    // A read must ask for 1 to MAX_READ_REGS registers inside the store.
    assign rd_end = 17'(r_addr) + 17'(r_cnt);
    assign rd_ok  = (r_cnt != 16'd0) && (r_cnt <= 16'(MAX_READ_REGS))
                    && (rd_end <= 17'(REG_DEPTH));

    assign slot_free = !r_out_valid || o_tx.ready;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= 4'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_b0     <= n_b0;
        r_fn     <= n_fn;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_crc_rx <= n_crc_rx;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_k       = r_k;
        n_b0      = r_b0;
        n_fn      = r_fn;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_crc_rx  = r_crc_rx;
        i_rx.ready = 1'b0;
        fb_we     = 1'b0;
        fb_re     = 1'b0;
        fb_raddr  = r_idx;
        rs_we     = 1'b0;
        rs_re     = 1'b0;
        crc_clr   = 1'b0;
        crc_upd   = 1'b0;
        crc_byte  = fb_rdata;
        push      = 1'b0;
        push_byte = fb_rdata;
        push_last = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_rx.ready = 1'b1;
                if (i_rx.valid) begin
                    // Only the first 8 bytes of a frame are kept.
                    if (r_count < 4'(FRAME_LEN)) begin
                        fb_we   = 1'b1;
                        n_count = r_count + 4'd1;
                    end
                    if (i_rx.frame_end) begin
                        n_count = 4'd0;
                        if (r_count >= 4'(FRAME_LEN - 1)) begin
                            n_idx   = FB_ADDR;
                            crc_clr = 1'b1;
                            n_state = ST_SCAN_RD;
                        end
                    end
                end
            end

            ST_SCAN_RD: begin
                fb_re   = 1'b1;
                n_state = ST_SCAN_DAT;
            end

            ST_SCAN_DAT: begin
                // The CRC covers the address, function and four data bytes.
                crc_upd = (r_idx < FB_CRC_LO);
                case (r_idx)
                    FB_ADDR:   n_b0            = fb_rdata;
                    FB_FN:     n_fn            = fb_rdata;
                    FB_REG_HI: n_addr[15:8]    = fb_rdata;
                    FB_REG_LO: n_addr[7:0]     = fb_rdata;
                    FB_VAL_HI: n_cnt[15:8]     = fb_rdata;
                    FB_VAL_LO: n_cnt[7:0]      = fb_rdata;
                    FB_CRC_LO: n_crc_rx[7:0]   = fb_rdata;
                    default:   n_crc_rx[15:8]  = fb_rdata;
                endcase
                if (r_idx == FB_CRC_HI) begin
                    n_state = ST_CHECK;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = ST_SCAN_RD;
                end
            end

            ST_CHECK: begin
                n_state = ST_IDLE;
                n_idx   = FB_ADDR;
                n_k     = '0;
                if ((r_b0 == r_slave_addr) && (crc_val == r_crc_rx)) begin
                    if (r_fn == FN_READ) begin
                        if (rd_ok) begin
                            crc_clr = 1'b1;
                            n_state = ST_RD_HDR;
                        end
                    end else if (r_fn == FN_WRITE) begin
                        // An out of range write changes nothing but is echoed.
                        rs_we   = (r_addr < 16'(REG_DEPTH));
                        n_state = ST_ECHO_RD;
                    end
                end
            end

            ST_RD_HDR: begin
                case (r_idx)
                    3'd0:    push_byte = r_slave_addr;
                    3'd1:    push_byte = FN_READ;
                    default: push_byte = {r_cnt[6:0], 1'b0};
                endcase
                crc_byte = push_byte;
                if (slot_free) begin
                    push    = 1'b1;
                    crc_upd = 1'b1;
                    n_idx   = r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        n_state = ST_RD_REQ;
                    end
                end
            end

            ST_RD_REQ: begin
                rs_re   = 1'b1;
                n_state = ST_RD_HI;
            end

            ST_RD_HI: begin
                push_byte = rs_rdata[15:8];
                crc_byte  = push_byte;
                if (slot_free) begin
                    push    = 1'b1;
                    crc_upd = 1'b1;
                    n_state = ST_RD_LO;
                end
            end

            ST_RD_LO: begin
                push_byte = rs_rdata[7:0];
                crc_byte  = push_byte;
                if (slot_free) begin
                    push    = 1'b1;
                    crc_upd = 1'b1;
                    n_k     = r_k + 1'b1;
                    if ((r_k + 1'b1) == r_cnt[KW-1:0]) begin
                        n_state = ST_CRC_LO;
                    end else begin
                        n_state = ST_RD_REQ;
                    end
                end
            end

            ST_CRC_LO: begin
                push_byte = crc_val[7:0];
                if (slot_free) begin
                    push    = 1'b1;
                    n_state = ST_CRC_HI;
                end
            end

            ST_CRC_HI: begin
                push_byte = crc_val[15:8];
                push_last = 1'b1;
                if (slot_free) begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_ECHO_RD: begin
                fb_re   = 1'b1;
                n_state = ST_ECHO_PUSH;
            end

            ST_ECHO_PUSH: begin
                push_last = (r_idx == FB_CRC_HI);
                if (slot_free) begin
                    push  = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == FB_CRC_HI) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ECHO_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_byte <= push_byte;
            r_out_last <= push_last;
        end
    end

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_out_byte;
    assign o_tx.last_byte = r_out_last;

endmodule

// ----- dv/tb_modbus_rtu_slave_frame_handler_core.sv -----
// One step of the Modbus CRC-16: fold in one byte, then shift eight times
// with the reflected polynomial.
function automatic bit [15:0] crc16_next(input bit [15:0] crc, input bit [7:0] data_byte);
    bit [15:0] c;
    c = crc ^ {8'h00, data_byte};
    for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ mrtu_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
endfunction

typedef struct packed {
    bit [7:0] data;
    bit       last;
} t_reply_byte;

// Shadow of the request handler: holding registers, frame capture and the
// station address, plus the reply bytes that are still owed on o_tx.
class reply_scoreboard;
    localparam int DEPTH = mrtu_pkg::REG_DEPTH_DEF;

    bit [15:0]   holding_regs[DEPTH];
    bit [7:0]    frame_bytes[mrtu_pkg::FRAME_LEN];
    int unsigned frame_count;
    bit [7:0]    station;
    t_reply_byte owed_replies[$];
    int unsigned mismatches;

    function new();
        foreach (holding_regs[i]) begin
            holding_regs[i] = 16'h0000;
        end
        holding_regs[1] = mrtu_pkg::REG1_RST;
        holding_regs[2] = mrtu_pkg::REG2_RST;
        frame_count = 0;
        station = mrtu_pkg::SLAVE_ADDR_RST;
        mismatches = 0;
    endfunction

    function int pending();
        return owed_replies.size();
    endfunction

    // Called for every byte accepted on i_rx.
    function void note_rx(input bit [7:0] rx_byte, input bit frame_end);
        bit [15:0] crc;
        bit [15:0] start;
        bit [15:0] count;
        bit [7:0]  reply[$];

        if (frame_count < mrtu_pkg::FRAME_LEN) begin
            frame_bytes[frame_count] = rx_byte;
            frame_count++;
        end
        if (!frame_end) begin
            return;
        end
        if (frame_count < mrtu_pkg::FRAME_LEN) begin
            frame_count = 0;
            return;
        end
        frame_count = 0;

        if (frame_bytes[mrtu_pkg::FB_ADDR] != station) begin
            return;
        end
        crc = mrtu_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc16_next(crc, frame_bytes[i]);
        end
        if (crc != {frame_bytes[mrtu_pkg::FB_CRC_HI], frame_bytes[mrtu_pkg::FB_CRC_LO]}) begin
            return;
        end
        start = {frame_bytes[mrtu_pkg::FB_REG_HI], frame_bytes[mrtu_pkg::FB_REG_LO]};
        count = {frame_bytes[mrtu_pkg::FB_VAL_HI], frame_bytes[mrtu_pkg::FB_VAL_LO]};

        if (frame_bytes[mrtu_pkg::FB_FN] == mrtu_pkg::FN_READ) begin
            if (count == 0 || count > mrtu_pkg::MAX_READ_REGS
                    || int'(start) + int'(count) > DEPTH) begin
                return;
            end
            reply.push_back(station);
            reply.push_back(mrtu_pkg::FN_READ);
            reply.push_back(8'(count * 2));
            for (int k = 0; k < int'(count); k++) begin
                reply.push_back(holding_regs[int'(start) + k][15:8]);
                reply.push_back(holding_regs[int'(start) + k][7:0]);
            end
            crc = mrtu_pkg::CRC_INIT;
            foreach (reply[k]) begin
                crc = crc16_next(crc, reply[k]);
            end
            reply.push_back(crc[7:0]);
            reply.push_back(crc[15:8]);
        end else if (frame_bytes[mrtu_pkg::FB_FN] == mrtu_pkg::FN_WRITE) begin
            if (int'(start) < DEPTH) begin
                holding_regs[start] = count;
            end
            foreach (frame_bytes[k]) begin
                reply.push_back(frame_bytes[k]);
            end
        end
        foreach (reply[k]) begin
            owed_replies.push_back('{data: reply[k], last: (k == reply.size() - 1)});
        end
    endfunction

    // Called for every byte accepted on o_tx.
    function void check_tx(input bit [7:0] tx_byte, input bit last_byte);
        t_reply_byte want;
        if (owed_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: unexpected reply byte %02h last=%0b", tx_byte, last_byte);
            end
            return;
        end
        want = owed_replies.pop_front();
        if (want.data != tx_byte || want.last != last_byte) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected byte %02h last=%0b, got byte %02h last=%0b",
                         want.data, want.last, tx_byte, last_byte);
            end
        end
    endfunction
endclass

module tb_modbus_rtu_slave_frame_handler_core;

    localparam int         DEPTH       = mrtu_pkg::REG_DEPTH_DEF;
    localparam int         MAX_REGS    = mrtu_pkg::MAX_READ_REGS;
    // Byte address of the station address register on the APB port.
    localparam logic [2:0] REG_STATION = 3'd0;
    // Cycles allowed after the last owed reply byte before the block is
    // taken as idle: covers the frame scan of a request that gets no reply.
    localparam int         QUIET_CYCLES = 60;

    // Kinds of request frames. The first two are well formed; the rest each
    // exercise one way a request is dropped or bent.
    typedef enum int {
        FK_READ,
        FK_WRITE,
        FK_SHORT,
        FK_LONG,
        FK_BAD_CRC,
        FK_WRONG_STATION,
        FK_UNKNOWN_FN,
        FK_ZERO_READ,
        FK_READ_PAST_END,
        FK_READ_TOO_MANY,
        FK_WRITE_OUT_OF_RANGE
    } t_frame_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mrtu_rx_if rx_ch();
    mrtu_tx_if tx_ch();

    // Percent chance per cycle that the sender holds back a byte, and that
    // the reply receiver stalls.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;

    reply_scoreboard sb = new();

    modbus_rtu_slave_frame_handler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_tx    (tx_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Reply receiver: a fresh stall decision every cycle.
    always @(posedge i_clk) begin
        tx_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Every reply transaction is checked against the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && tx_ch.valid && tx_ch.ready) begin
            sb.check_tx(tx_ch.tx_byte, tx_ch.last_byte);
        end
    end

    // Hands one byte to the block. Valid is only dropped when a gap is
    // actually taken, so back-to-back bytes keep it high without a glitch.
    task automatic send_byte(input bit [7:0] data_byte, input bit frame_end);
        while ($urandom_range(99) < idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= data_byte;
        rx_ch.frame_end <= frame_end;
        do @(posedge i_clk); while (!rx_ch.ready);
        sb.note_rx(data_byte, frame_end);
        bytes_sent++;
    endtask

    // Builds a request from its fields, appends the CRC (optionally
    // corrupted), truncates it to keep bytes, adds extra trailing bytes,
    // and sends it with frame_end on its final byte.
    task automatic send_frame(input bit [7:0] station, input bit [7:0] fn,
                              input bit [15:0] reg_addr, input bit [15:0] value,
                              input bit [15:0] crc_flip, input int keep, input int extra);
        bit [7:0]  frame[$];
        bit [15:0] crc;
        frame = {station, fn, reg_addr[15:8], reg_addr[7:0], value[15:8], value[7:0]};
        crc = mrtu_pkg::CRC_INIT;
        foreach (frame[i]) begin
            crc = crc16_next(crc, frame[i]);
        end
        crc ^= crc_flip;
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        while (frame.size() > keep) begin
            void'(frame.pop_back());
        end
        repeat (extra) begin
            frame.push_back(8'($urandom));
        end
        foreach (frame[i]) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // Random request of the given kind. Fields start out well formed for
    // the current station address and are then bent as the kind asks.
    task automatic send_request(input t_frame_kind kind);
        bit [7:0]  station;
        bit [7:0]  fn;
        bit [15:0] reg_addr;
        bit [15:0] value;
        bit [15:0] crc_flip;
        int        keep;
        int        extra;
        int        top;

        station  = sb.station;
        crc_flip = 16'h0000;
        keep     = mrtu_pkg::FRAME_LEN;
        extra    = 0;
        if (kind == FK_READ) begin
            fn = mrtu_pkg::FN_READ;
        end else if (kind == FK_WRITE) begin
            fn = mrtu_pkg::FN_WRITE;
        end else begin
            fn = $urandom_range(1) ? mrtu_pkg::FN_READ : mrtu_pkg::FN_WRITE;
        end
        reg_addr = 16'($urandom_range(DEPTH - 1));
        if (fn == mrtu_pkg::FN_READ) begin
            top = DEPTH - int'(reg_addr);
            if (top > MAX_REGS) begin
                top = MAX_REGS;
            end
            value = 16'($urandom_range(top, 1));
        end else begin
            value = 16'($urandom);
        end

        case (kind)
            FK_SHORT: begin
                keep = $urandom_range(mrtu_pkg::FRAME_LEN - 1, 1);
            end
            FK_LONG: begin
                extra = $urandom_range(4, 1);
            end
            FK_BAD_CRC: begin
                crc_flip = 16'h0001 << $urandom_range(15);
            end
            FK_WRONG_STATION: begin
                station ^= 8'($urandom_range(255, 1));
            end
            FK_UNKNOWN_FN: begin
                do fn = 8'($urandom);
                while (fn == mrtu_pkg::FN_READ || fn == mrtu_pkg::FN_WRITE);
            end
            FK_ZERO_READ: begin
                fn    = mrtu_pkg::FN_READ;
                value = 16'h0000;
            end
            FK_READ_PAST_END: begin
                fn = mrtu_pkg::FN_READ;
                if ($urandom_range(1)) begin
                    reg_addr = 16'($urandom_range(DEPTH - 1, 1));
                    value    = 16'($urandom_range(MAX_REGS, DEPTH - int'(reg_addr) + 1));
                end else begin
                    reg_addr = 16'($urandom_range(16'hFFFF, DEPTH));
                    value    = 16'($urandom_range(MAX_REGS, 1));
                end
            end
            FK_READ_TOO_MANY: begin
                fn       = mrtu_pkg::FN_READ;
                reg_addr = $urandom_range(1) ? 16'h0000 : 16'($urandom);
                value    = 16'($urandom_range(16'hFFFF, MAX_REGS + 1));
            end
            FK_WRITE_OUT_OF_RANGE: begin
                fn       = mrtu_pkg::FN_WRITE;
                reg_addr = 16'($urandom_range(16'hFFFF, DEPTH));
            end
            default: begin
            end
        endcase
        send_frame(station, fn, reg_addr, value, crc_flip, keep, extra);
    endtask

    // Mostly well-formed reads and writes; the rest spread over the kinds
    // of request that the block must drop or treat specially.
    function automatic t_frame_kind pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) begin
            return FK_READ;
        end else if (r < 60) begin
            return FK_WRITE;
        end
        return t_frame_kind'(int'(FK_SHORT) + int'(r - 60) % 9);
    endfunction

    // Waits until every owed reply byte has arrived, then lets the block
    // finish scanning any trailing frame that produces no reply.
    task automatic wait_quiet();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the station address: setup cycle, then access cycle.
    task automatic write_station(input bit [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_STATION;
        pwdata  <= {24'h000000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.station = value;
    endtask

    initial begin
        int unsigned phase_start;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= REG_STATION;
        pwdata          <= 32'h0;
        rx_ch.valid     <= 1'b0;
        rx_ch.rx_byte   <= 8'h00;
        rx_ch.frame_end <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Four phases of back-pressure: none, a sparse sender, a stalling
        // receiver, then both moderately. The station address moves to a
        // new value (both extremes among them) between phases.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                rx_ch.valid <= 1'b0;
                wait_quiet();
                case (ph)
                    1: write_station(8'h00);
                    2: write_station(8'hFF);
                    default: write_station(8'($urandom_range(254, 2)));
                endcase
            end
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase

            if (ph == 0) begin
                // Longest possible read over the power-on register values:
                // a 37-byte reply.
                send_frame(mrtu_pkg::SLAVE_ADDR_RST, mrtu_pkg::FN_READ, 16'h0000,
                           16'(MAX_REGS), 16'h0000, mrtu_pkg::FRAME_LEN, 0);
                // All-ones write into the top register.
                send_frame(mrtu_pkg::SLAVE_ADDR_RST, mrtu_pkg::FN_WRITE, 16'(DEPTH - 1),
                           16'hFFFF, 16'h0000, mrtu_pkg::FRAME_LEN, 0);
                // A frame of a single byte is dropped.
                send_frame(mrtu_pkg::SLAVE_ADDR_RST, mrtu_pkg::FN_READ, 16'h0000,
                           16'h0001, 16'h0000, 1, 0);
                // Write to the highest register number, with a trailing byte
                // after the eighth: still echoed, nothing written.
                send_frame(mrtu_pkg::SLAVE_ADDR_RST, mrtu_pkg::FN_WRITE, 16'hFFFF,
                           16'h1234, 16'h0000, mrtu_pkg::FRAME_LEN, 1);
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 55) begin
                send_request(pick_kind());
            end
        end

        rx_ch.valid <= 1'b0;
        wait_quiet();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
